// ===== hw/rtl/gaussian_blur_5x5_assert.svh =====
// Assertion macros shared by the gaussian_blur_5x5 RTL.
`ifndef GAUSSIAN_BLUR_5X5_ASSERT_SVH
`define GAUSSIAN_BLUR_5X5_ASSERT_SVH

// Consequent must hold at the same edge as the antecedent.
`define GB5_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold at the edge after the antecedent.
`define GB5_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/gb5_pkg.sv =====
// Shared types, constants and helper functions of the 5x5 Gaussian blur.
`timescale 1ns / 1ps

package gb5_pkg;

   // field widths
   localparam int PIX_W      = 8;
   localparam int POS_W      = 10;
   localparam int SIZE_W     = 11;
   localparam int COEFF_W    = 16;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_PAD_W  = RSP_DATA_W - PIX_W - 2 * POS_W;

   // window geometry
   localparam int WIN_N     = 5;
   localparam int LINES     = WIN_N - 1;
   localparam int LINE_W    = LINES * PIX_W;
   localparam int BORDER    = 2;
   localparam int WIN_REACH = WIN_N - 1;
   localparam int MIN_SIZE  = 5;
   localparam int SIZE_RESET = 1024;

   // arithmetic widths: a class sums at most eight pixels, six products are added
   localparam int NUM_CLASS = 6;
   localparam int CLS_W     = 3;
   localparam int CSUM_W    = PIX_W + 3;
   localparam int PROD_W    = COEFF_W + CSUM_W;
   localparam int ACC_W     = PROD_W + 3;
   localparam int FRAC_BITS = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH      = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT     = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEFF_CORNER     = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEFF_CENTER     = 4'd7;

   // weight classes, in coefficient register order
   localparam logic [CLS_W-1:0] CLS_CORNER     = 3'd0;
   localparam logic [CLS_W-1:0] CLS_OUTER_SIDE = 3'd1;
   localparam logic [CLS_W-1:0] CLS_OUTER_AXIS = 3'd2;
   localparam logic [CLS_W-1:0] CLS_INNER_DIAG = 3'd3;
   localparam logic [CLS_W-1:0] CLS_INNER_AXIS = 3'd4;
   localparam logic [CLS_W-1:0] CLS_CENTER     = 3'd5;

   typedef logic [NUM_CLASS-1:0][COEFF_W-1:0] coeff_set_type;
   typedef logic [NUM_CLASS-1:0][CSUM_W-1:0]  class_sum_type;

   localparam coeff_set_type COEFF_RESET = {
      16'd16384, 16'd7537, 16'd3408, 16'd721, 16'd328, 16'd33
   };

   // pixel and position info that travels with an item down the pipeline
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             interior;
      logic             border;
   } side_type;

   // one result item
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             filtered;
      logic             last;
   } result_type;

   // stage transfers of the pipeline
   typedef struct packed {
      logic acc;
      logic s1_mv;
      logic s2_mv;
      logic s3_mv;
   } pipe_mv_type;

   // weight class of window tap (dr, dc), both 0..4, center at (2, 2)
   function automatic logic [CLS_W-1:0] weight_class(input logic [2:0] dr,
                                                     input logic [2:0] dc);
      logic [1:0]       ar;
      logic [1:0]       ac;
      logic [CLS_W-1:0] cls;
      ar = (dr > 3'd2) ? 2'(dr - 3'd2) : 2'(3'd2 - dr);
      ac = (dc > 3'd2) ? 2'(dc - 3'd2) : 2'(3'd2 - dc);
      case ({ar, ac})
         4'b0000:          cls = CLS_CENTER;
         4'b0001, 4'b0100: cls = CLS_INNER_AXIS;
         4'b0101:          cls = CLS_INNER_DIAG;
         4'b0010, 4'b1000: cls = CLS_OUTER_AXIS;
         4'b0110, 4'b1001: cls = CLS_OUTER_SIDE;
         default:          cls = CLS_CORNER;
      endcase
      return cls;
   endfunction

endpackage

// ===== hw/rtl/gaussian_blur_5x5.sv =====
// Top level of the streaming 5x5 Gaussian blur.
// Takes one grey pixel per clock in raster order while req_tready is high,
// and gives each pixel at least two positions from every frame edge as the
// saturated Q0.16 weighted sum of its 5x5 neighbourhood, and every border
// pixel unchanged. The filtered value of pixel (r,c) comes out when pixel
// (r+2,c+2) arrives, so each result carries its row and column; a pixel
// gives zero, one or two results, and a two-result pixel occupies the output
// for both results, which can hold off input when the pipeline is full;
// throughput is one item per clock unless this or an output stall holds it
// off. Items pass through the pipeline of line store read, window shift,
// class sums, six coefficient multipliers and the final add. The four line
// stores are one memory of MAX_WIDTH 32-bit words, read on accept and written
// back one stage later; it needs no clearing after reset. Configuration
// writes on the csr_ port are always ready and take effect at the next item.
`timescale 1ns / 1ps
`include "gaussian_blur_5x5_assert.svh"

module gaussian_blur_5x5 import gb5_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] pixel_in
   input  logic                  req_tuser,   // [0] start_of_frame
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] pixel_out, [17:8] out_row,
                                              // [27:18] out_col, [31:28] zero
   output logic                  rsp_tuser,   // [0] is_filtered
   output logic                  rsp_tlast,   // last_of_run
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int CLW = $clog2(MAX_WIDTH);

   logic [WW-1:0]    width_eff;
   logic [HW-1:0]    height_eff;
   coeff_set_type    coeffs;
   side_type         pos_side;
   logic [CLW-1:0]   col_addr;
   class_sum_type    sums;
   logic [PIX_W-1:0] filt_pix;
   pipe_mv_type      mv;

   logic     s1_vld_ff;
   logic     s2_vld_ff;
   logic     s3_vld_ff;
   logic     s4_vld_ff;
   side_type s1_ff;
   side_type s2_ff;
   side_type s3_ff;
   side_type s4_ff;
   logic     s1_mv;
   logic     s2_mv;
   logic     s3_mv;
   logic     s4_mv;
   logic     acc;
   logic     s4_has;
   logic     out_free;
   logic     out_load;

   result_type int_res;
   result_type pass_res;
   result_type first_res;
   result_type rsp_item;

   assign csr_ready = 1'b1;

   gb5_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (csr_valid && csr_ready),
      .wr_index   (csr_index),
      .wr_data    (csr_data),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .coeffs     (coeffs)
   );

   gb5_pos #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_pos (
      .clock      (clock),
      .reset      (reset),
      .acc        (acc),
      .pixel      (req_tdata[PIX_W-1:0]),
      .sof        (req_tuser),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .side       (pos_side),
      .col_addr   (col_addr)
   );

   // stage transfers: each stage moves when the next one is empty or moving
   assign s4_has = s4_ff.interior || s4_ff.border;
   assign s4_mv  = s4_vld_ff && (!s4_has || out_free);
   assign s3_mv  = s3_vld_ff && (!s4_vld_ff || s4_mv);
   assign s2_mv  = s2_vld_ff && (!s3_vld_ff || s3_mv);
   assign s1_mv  = s1_vld_ff && (!s2_vld_ff || s2_mv);
   assign req_tready = !s1_vld_ff || s1_mv;
   assign acc        = req_tvalid && req_tready;
   assign out_load   = s4_mv && s4_has;

   assign mv.acc   = acc;
   assign mv.s1_mv = s1_mv;
   assign mv.s2_mv = s2_mv;
   assign mv.s3_mv = s3_mv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= acc   || (s1_vld_ff && !s1_mv);
         s2_vld_ff <= s1_mv || (s2_vld_ff && !s2_mv);
         s3_vld_ff <= s2_mv || (s3_vld_ff && !s3_mv);
         s4_vld_ff <= s3_mv || (s4_vld_ff && !s4_mv);
      end
   end

   // item info rides alongside the datapath
   always_ff @(posedge clock) begin
      if (acc)
         s1_ff <= pos_side;
      if (s1_mv)
         s2_ff <= s1_ff;
      if (s2_mv)
         s3_ff <= s2_ff;
      if (s3_mv)
         s4_ff <= s3_ff;
   end

   gb5_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .mv      (mv),
      .rd_addr (col_addr),
      .s1_pix  (s1_ff.pixel),
      .sums    (sums)
   );

   gb5_mac u_mac (
      .clock    (clock),
      .mv       (mv),
      .sums     (sums),
      .coeffs   (coeffs),
      .filt_pix (filt_pix)
   );

   // delayed interior result first, then the item's own pass-through
   always_comb begin
      int_res.pixel    = filt_pix;
      int_res.row      = s4_ff.row - POS_W'(BORDER);
      int_res.col      = s4_ff.col - POS_W'(BORDER);
      int_res.filtered = 1'b1;
      int_res.last     = !s4_ff.border;

      pass_res.pixel    = s4_ff.pixel;
      pass_res.row      = s4_ff.row;
      pass_res.col      = s4_ff.col;
      pass_res.filtered = 1'b0;
      pass_res.last     = 1'b1;

      first_res = s4_ff.interior ? int_res : pass_res;
   end

   gb5_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .first     (first_res),
      .second    (pass_res),
      .two       (s4_ff.interior && s4_ff.border),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_item  (rsp_item),
      .free      (out_free)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_item.col, rsp_item.row, rsp_item.pixel};
   assign rsp_tuser = rsp_item.filtered;
   assign rsp_tlast = rsp_item.last;

   // a run of two always opens with the filtered result
   `GB5_ASSERT_SAME(a_run_opens_filtered, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tuser, "non-last result is not a filtered pixel")
   // the second result of a run follows at once
   `GB5_ASSERT_NEXT(a_run_continues, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid, "second result of a run missing")
   // a stalled output keeps the last stage occupied
   `GB5_ASSERT_NEXT(a_stall_holds_s4, clock, reset, rsp_tvalid && !rsp_tready && s4_vld_ff && s4_has, s4_vld_ff, "last stage lost an item during output stall")

endmodule

// ===== hw/rtl/gb5_csr.sv =====
// Configuration registers with clamped frame size.
`timescale 1ns / 1ps

module gb5_csr import gb5_pkg::*; #(
   parameter int  MAX_WIDTH  = 1024,
   parameter int  MAX_HEIGHT = 1024,
   localparam int WW = $clog2(MAX_WIDTH + 1),
   localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [CSR_IDX_W-1:0]  wr_index,
   input  logic [CSR_DATA_W-1:0] wr_data,
   output logic [WW-1:0]         width_eff,
   output logic [HW-1:0]         height_eff,
   output coeff_set_type         coeffs
);

   localparam int MW = (WW > HW) ? WW : HW;
   localparam int LW = (MW > SIZE_W) ? MW : SIZE_W;

   logic [SIZE_W-1:0] width_ff;
   logic [SIZE_W-1:0] height_ff;
   coeff_set_type     coeff_ff;
   logic [CLS_W-1:0]  coeff_sel;
   logic [LW-1:0]     w_x;
   logic [LW-1:0]     h_x;

   assign coeff_sel = CLS_W'(wr_index - REG_COEFF_CORNER);

   // register writes; an index past the list is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_W'(SIZE_RESET);
         height_ff <= SIZE_W'(SIZE_RESET);
         coeff_ff  <= COEFF_RESET;
      end else if (wr_en) begin
         case (wr_index)
            REG_IMAGE_WIDTH:  width_ff  <= wr_data[SIZE_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= wr_data[SIZE_W-1:0];
            default: begin
               if (wr_index inside {[REG_COEFF_CORNER:REG_COEFF_CENTER]})
                  coeff_ff[coeff_sel] <= wr_data[COEFF_W-1:0];
            end
         endcase
      end
   end

   // clamp the frame size to MIN_SIZE..MAX
   always_comb begin
      w_x = LW'(width_ff);
      if (w_x < LW'(MIN_SIZE))
         w_x = LW'(MIN_SIZE);
      else if (w_x > LW'(MAX_WIDTH))
         w_x = LW'(MAX_WIDTH);
      h_x = LW'(height_ff);
      if (h_x < LW'(MIN_SIZE))
         h_x = LW'(MIN_SIZE);
      else if (h_x > LW'(MAX_HEIGHT))
         h_x = LW'(MAX_HEIGHT);
   end

   assign width_eff  = WW'(w_x);
   assign height_eff = HW'(h_x);
   assign coeffs     = coeff_ff;

endmodule

// ===== hw/rtl/gb5_pos.sv =====
// Row and column counters and the interior and border tests of each item.
`timescale 1ns / 1ps

module gb5_pos import gb5_pkg::*; #(
   parameter int  MAX_WIDTH  = 1024,
   parameter int  MAX_HEIGHT = 1024,
   localparam int WW  = $clog2(MAX_WIDTH + 1),
   localparam int HW  = $clog2(MAX_HEIGHT + 1),
   localparam int CLW = $clog2(MAX_WIDTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             acc,
   input  logic [PIX_W-1:0] pixel,
   input  logic             sof,
   input  logic [WW-1:0]    width_eff,
   input  logic [HW-1:0]    height_eff,
   output side_type         side,
   output logic [CLW-1:0]   col_addr
);

   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int XW = ((WW > HW) ? WW : HW) + 1;

   logic [RW-1:0]  row_ff;
   logic [RW-1:0]  row_in;
   logic [CLW-1:0] col_ff;
   logic [CLW-1:0] col_in;
   logic [XW-1:0]  r_x;
   logic [XW-1:0]  c_x;
   logic [XW-1:0]  w_x;
   logic [XW-1:0]  h_x;
   logic [XW-1:0]  r_nx;
   logic [XW-1:0]  c_nx;

   // position of the offered item and the counters after it
   always_comb begin
      r_x  = sof ? '0 : XW'(row_ff);
      c_x  = sof ? '0 : XW'(col_ff);
      w_x  = XW'(width_eff);
      h_x  = XW'(height_eff);
      r_nx = r_x + XW'(1);
      c_nx = c_x + XW'(1);

      side.pixel    = pixel;
      side.row      = POS_W'(r_x);
      side.col      = POS_W'(c_x);
      side.interior = (r_x >= XW'(WIN_REACH)) && (r_x < h_x) &&
                      (c_x >= XW'(WIN_REACH)) && (c_x < w_x);
      side.border   = (r_x < XW'(BORDER)) || (r_x + XW'(BORDER) >= h_x) ||
                      (c_x < XW'(BORDER)) || (c_x + XW'(BORDER) >= w_x);
      col_addr      = CLW'(c_x);

      if (c_nx >= w_x) begin
         col_in = '0;
         row_in = (r_nx >= h_x) ? '0 : RW'(r_nx);
      end else begin
         col_in = CLW'(c_nx);
         row_in = RW'(r_x);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (acc) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

// ===== hw/rtl/gb5_window.sv =====
// Line store memory, 5x5 window and per-class pixel sums.
`timescale 1ns / 1ps

module gb5_window import gb5_pkg::*; #(
   parameter int  MAX_WIDTH = 1024,
   localparam int CLW = $clog2(MAX_WIDTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  pipe_mv_type      mv,
   input  logic [CLW-1:0]   rd_addr,
   input  logic [PIX_W-1:0] s1_pix,
   output class_sum_type    sums
);

   // one word per column: byte 0 is the oldest row, byte 3 the newest
   logic [LINE_W-1:0] line_mem [MAX_WIDTH];
   logic [LINE_W-1:0] rd_ff;
   logic [LINE_W-1:0] wr_word;
   logic [CLW-1:0]    addr_ff;

   logic [WIN_N-1:0][WIN_N-1:0][PIX_W-1:0] win_ff;
   class_sum_type sums_ff;
   class_sum_type sums_in;

   assign wr_word = {s1_pix, rd_ff[LINE_W-1:PIX_W]};

   // read on accept, write back the shifted column when the item leaves stage 1;
   // a same-column read in that cycle takes the new word
   always_ff @(posedge clock) begin
      if (mv.s1_mv)
         line_mem[addr_ff] <= wr_word;
      if (mv.acc) begin
         addr_ff <= rd_addr;
         if (mv.s1_mv && (rd_addr == addr_ff))
            rd_ff <= wr_word;
         else
            rd_ff <= line_mem[rd_addr];
      end
   end

   // shift the window left and load the new column
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (mv.s1_mv) begin
         for (int k = 0; k < WIN_N; k++) begin
            for (int j = 0; j < WIN_N - 1; j++)
               win_ff[k][j] <= win_ff[k][j+1];
         end
         for (int k = 0; k < LINES; k++)
            win_ff[k][WIN_N-1] <= rd_ff[k*PIX_W +: PIX_W];
         win_ff[WIN_N-1][WIN_N-1] <= s1_pix;
      end
   end

   // pixels of equal weight are added before the multiply
   always_comb begin
      sums_in = '0;
      for (int r = 0; r < WIN_N; r++) begin
         for (int c = 0; c < WIN_N; c++)
            sums_in[weight_class(3'(r), 3'(c))] =
               sums_in[weight_class(3'(r), 3'(c))] + CSUM_W'(win_ff[r][c]);
      end
   end

   always_ff @(posedge clock) begin
      if (mv.s2_mv)
         sums_ff <= sums_in;
   end

   assign sums = sums_ff;

endmodule

// ===== hw/rtl/gb5_mac.sv =====
// Coefficient products, final sum, truncation and saturation.
`timescale 1ns / 1ps

module gb5_mac import gb5_pkg::*; (
   input  logic             clock,
   input  pipe_mv_type      mv,
   input  class_sum_type    sums,
   input  coeff_set_type    coeffs,
   output logic [PIX_W-1:0] filt_pix
);

   logic [NUM_CLASS-1:0][PROD_W-1:0] prod_ff;
   logic [NUM_CLASS-1:0][PROD_W-1:0] prod_in;
   logic [ACC_W-1:0]                 total;
   logic [ACC_W-FRAC_BITS-1:0]       scaled;

   // one 16x11 multiply per weight class
   always_comb begin
      for (int i = 0; i < NUM_CLASS; i++)
         prod_in[i] = PROD_W'(coeffs[i]) * PROD_W'(sums[i]);
   end

   always_ff @(posedge clock) begin
      if (mv.s3_mv)
         prod_ff <= prod_in;
   end

   // add the six products, drop the fraction, saturate
   always_comb begin
      total = '0;
      for (int i = 0; i < NUM_CLASS; i++)
         total = total + ACC_W'(prod_ff[i]);
      scaled = total[ACC_W-1:FRAC_BITS];
      if (scaled > (ACC_W-FRAC_BITS)'({PIX_W{1'b1}}))
         filt_pix = {PIX_W{1'b1}};
      else
         filt_pix = scaled[PIX_W-1:0];
   end

endmodule

// ===== hw/rtl/gb5_out.sv =====
// Two-slot result register that serializes the results of one item.
`timescale 1ns / 1ps

module gb5_out import gb5_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type first,
   input  result_type second,
   input  logic       two,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output result_type rsp_item,
   output logic       free
);

   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   result_type slot0_ff;
   result_type slot0_in;
   result_type slot1_ff;
   result_type slot1_in;
   logic       pop;

   assign pop  = (cnt_ff != 2'd0) && rsp_ready;
   assign free = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && pop);

   // load a fresh run or step to the second slot
   always_comb begin
      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (load) begin
         cnt_in   = two ? 2'd2 : 2'd1;
         slot0_in = first;
         slot1_in = second;
      end else if (pop) begin
         cnt_in   = cnt_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         cnt_ff <= 2'd0;
      else
         cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_item  = slot0_ff;

endmodule
